>>> src/utfhb_pkg.sv
// Shared types and constants for the UDP test frame header builder.
package utfhb_pkg;

  localparam int unsigned FRAME_WORDS = 14;
  localparam int unsigned FRAME_BITS  = FRAME_WORDS * 64;
  localparam int unsigned NEED_W      = 7;
  localparam int unsigned APB_AW      = 6;
  localparam int unsigned APB_DW      = 64;

  localparam logic [63:0] MAGIC_WORD   = 64'h0000_0811_136e_e17e;
  localparam logic [15:0] UDP_SRC_PORT = 16'd1024;
  localparam logic [7:0]  DEF_TTL      = 8'd64;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  NH_DSTOPT    = 8'd60;
  localparam logic [15:0] ETYPE_IP4    = 16'h0800;
  localparam logic [15:0] ETYPE_IP6    = 16'h86DD;
  localparam logic [31:0] FLOW_PLAIN   = 32'h6000_0000;
  localparam logic [31:0] FLOW_TUNNEL  = 32'h600e_4a1e;
  localparam logic [15:0] FRAG_DF      = 16'h4000;
  localparam logic [15:0] IP4_VER_IHL  = 16'h4500;
  localparam logic [63:0] DSTOPT_BYTES = 64'h0400_0401_0401_0100;

  typedef enum logic [2:0] {
    CMD_IP4_UDP    = 3'd0,
    CMD_IP6_UDP    = 3'd1,
    CMD_IP4_IN_IP6 = 3'd2,
    CMD_ENCAP      = 3'd3,
    CMD_DECAP      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_REMOTE_MAC    = 3'd0,
    REG_LOCAL_MAC     = 3'd1,
    REG_SELF_IP6_HIGH = 3'd2,
    REG_SELF_IP6_LOW  = 3'd3,
    REG_DEST_IP6_HIGH = 3'd4,
    REG_DEST_IP6_LOW  = 3'd5,
    REG_LOCAL_IP4     = 3'd6,
    REG_REMOTE_IP4    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [47:0] remote_mac;
    logic [47:0] local_mac;
    logic [63:0] self_ip6_high;
    logic [63:0] self_ip6_low;
    logic [63:0] dest_ip6_high;
    logic [63:0] dest_ip6_low;
    logic [31:0] local_ip4;
    logic [31:0] remote_ip4;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] frame_len;
    logic        stamp_enable;
    logic [63:0] stamp_value;
  } req_t;

endpackage

>>> src/udp_test_frame_header_builder.sv
// Top level of the UDP test frame header builder: config registers, input stage, word queue.
// Usage:
//   Requests enter on the s_axis channel (tuser = mode, tdata = length, stamp flag, stamp).
//   Each request yields the frame's leading bytes on m_axis as 64-bit words, earliest byte
//   in bits 63..56, tlast on the final word; tuser marks a too-short request, which gives
//   a single word with no valid bytes. Modes 5..7 are dropped without a result.
//   Registers are written over the APB port at byte address 8*index; the user must write
//   them only while idle, which the block itself does not enforce.
// Flow: a request waits in the input stage until the word queue is free, then is loaded.
// Words: a request yields 2 words (mode 4), 7 or 8 (mode 0), 9 or 10 (mode 1),
//   13 or 14 (mode 2), 8 (mode 3), 1 on error. The word queue is reloaded in the cycle
//   its last word leaves, so frames follow gap-free.
// Reset: registers, the port counter and both stages clear; no item is held.
// Stall: while m_axis_tready is low the current word holds; one more request is taken
//   into the input stage and s_axis_tready then drops until the queue frees up.
module udp_test_frame_header_builder import utfhb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [15:0] frame_len, [16] stamp_enable, [80:17] stamp_value, [87:81] zero
  input  logic [87:0]       s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [63:0] header_word, [67:64] valid_bytes, [71:68] zero
  output logic [71:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  // [0] too_short
  output logic              m_axis_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg_q;

  logic in_accept, cmd_known, load_en, out_take, out_last;
  logic s1_valid_q, s1_valid_d;
  req_t s1_req_q;
  logic ov_q, ov_d;
  logic err_q;
  logic [NEED_W-1:0] rem_q;
  logic [15:0] port_q, port_d;
  logic [FRAME_WORDS-1:0][63:0] frame_q;
  logic [FRAME_WORDS-1:0][63:0] words;
  logic [NEED_W-1:0] need;
  logic too_short;
  logic [3:0] vb;
  reg_idx_e wr_idx, rd_idx;

  // configuration port
  assign pready = 1'b1;
  assign wr_idx = reg_idx_e'(paddr[5:3]);
  assign rd_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (wr_idx)
        REG_REMOTE_MAC:    cfg_q.remote_mac    <= pwdata[47:0];
        REG_LOCAL_MAC:     cfg_q.local_mac     <= pwdata[47:0];
        REG_SELF_IP6_HIGH: cfg_q.self_ip6_high <= pwdata;
        REG_SELF_IP6_LOW:  cfg_q.self_ip6_low  <= pwdata;
        REG_DEST_IP6_HIGH: cfg_q.dest_ip6_high <= pwdata;
        REG_DEST_IP6_LOW:  cfg_q.dest_ip6_low  <= pwdata;
        REG_LOCAL_IP4:     cfg_q.local_ip4     <= pwdata[31:0];
        REG_REMOTE_IP4:    cfg_q.remote_ip4    <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (rd_idx)
      REG_REMOTE_MAC:    prdata = {16'h0, cfg_q.remote_mac};
      REG_LOCAL_MAC:     prdata = {16'h0, cfg_q.local_mac};
      REG_SELF_IP6_HIGH: prdata = cfg_q.self_ip6_high;
      REG_SELF_IP6_LOW:  prdata = cfg_q.self_ip6_low;
      REG_DEST_IP6_HIGH: prdata = cfg_q.dest_ip6_high;
      REG_DEST_IP6_LOW:  prdata = cfg_q.dest_ip6_low;
      REG_LOCAL_IP4:     prdata = {32'h0, cfg_q.local_ip4};
      REG_REMOTE_IP4:    prdata = {32'h0, cfg_q.remote_ip4};
      default:           prdata = '0;
    endcase
  end

  // handshakes
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign cmd_known = s_axis_tuser <= CMD_DECAP;
  assign out_take  = m_axis_tvalid && m_axis_tready;
  assign out_last  = err_q || (rem_q <= NEED_W'(8));
  assign load_en   = s1_valid_q && (!ov_q || (out_take && out_last));
  assign s_axis_tready = !s1_valid_q || load_en;

  // input stage; unknown modes are taken and dropped here
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = cmd_known;
    end else if (load_en) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q.cmd          <= cmd_e'(s_axis_tuser);
      s1_req_q.frame_len    <= s_axis_tdata[15:0];
      s1_req_q.stamp_enable <= s_axis_tdata[16];
      s1_req_q.stamp_value  <= s_axis_tdata[80:17];
    end
  end

  utfhb_composer u_composer (
    .req_i       (s1_req_q),
    .cfg_i       (cfg_q),
    .port_i      (port_q),
    .words_o     (words),
    .need_o      (need),
    .too_short_o (too_short)
  );

  always_comb begin
    ov_d = ov_q;
    if (load_en) begin
      ov_d = 1'b1;
    end else if (out_take && out_last) begin
      ov_d = 1'b0;
    end
    port_d = port_q;
    if (load_en && !too_short &&
        (s1_req_q.cmd == CMD_IP4_UDP || s1_req_q.cmd == CMD_IP6_UDP ||
         s1_req_q.cmd == CMD_IP4_IN_IP6)) begin
      port_d = port_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      ov_q       <= 1'b0;
      port_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      ov_q       <= ov_d;
      port_q     <= port_d;
    end
  end

  // word queue: head word is the output register, shifts down as words leave
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      frame_q <= words;
      rem_q   <= need;
      err_q   <= too_short;
    end else if (out_take) begin
      for (int k = 0; k < FRAME_WORDS - 1; k++) begin
        frame_q[k] <= frame_q[k+1];
      end
      frame_q[FRAME_WORDS-1] <= '0;
      rem_q <= rem_q - NEED_W'(8);
    end
  end

  assign vb = err_q ? 4'd0 : ((rem_q >= NEED_W'(8)) ? 4'd8 : rem_q[3:0]);

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'h0, vb, (err_q ? 64'h0 : frame_q[0])};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = err_q;

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[67:64] == 4'd0))
    else $error("error item not a single empty word");
  a_full_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[67:64] == 4'd8))
    else $error("inner word not full");
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !out_last) |=> m_axis_tvalid)
    else $error("frame ended before its last word");
  a_port_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_en |=> $stable(port_q))
    else $error("port counter moved without a request");
`endif

endmodule

>>> src/utfhb_composer.sv
// Builds the header bytes of one request as a row of 64-bit words.
module utfhb_composer import utfhb_pkg::*; (
  input  req_t                     req_i,
  input  cfg_t                     cfg_i,
  input  logic [15:0]              port_i,
  output logic [FRAME_WORDS-1:0][63:0] words_o,
  output logic [NEED_W-1:0]        need_o,
  output logic                     too_short_o
);

  function automatic logic [63:0] bswap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  // ones'-complement sum of the non-checksum words (the identification word is zero), fully folded
  function automatic logic [15:0] ip4_csum(input logic [15:0] tlen, input logic [15:0] frag,
                                           input logic [31:0] src, input logic [31:0] dst);
    logic [19:0] s;
    logic [16:0] f;
    logic [15:0] c;
    s = 20'(IP4_VER_IHL) + 20'(tlen) + 20'(frag) + 20'({DEF_TTL, PROTO_UDP})
      + 20'(src[31:16]) + 20'(src[15:0]) + 20'(dst[31:16]) + 20'(dst[15:0]);
    f = 17'(s[19:16]) + 17'(s[15:0]);
    if (f > 17'd65535) f = f - 17'd65535;
    c = ~f[15:0];
    if (c == 16'h0000) c = 16'hFFFF;
    return c;
  endfunction

  logic [15:0]  len;
  logic [63:0]  magic_le;
  logic [63:0]  stamp_le;
  logic [15:0]  len14, len34, len54, len62, len82;
  logic [15:0]  csum_plain, csum_tunnel;
  logic [111:0] eth_ip4, eth_ip6;
  logic [319:0] ip6_plain, ip6_tunnel;
  logic [FRAME_BITS-1:0] frame;
  logic [NEED_W-1:0] d;

  assign len      = req_i.frame_len;
  assign magic_le = bswap64(MAGIC_WORD);
  assign stamp_le = req_i.stamp_enable ? bswap64(req_i.stamp_value) : 64'h0;
  assign len14    = len - 16'd14;
  assign len34    = len - 16'd34;
  assign len54    = len - 16'd54;
  assign len62    = len - 16'd62;
  assign len82    = len - 16'd82;

  assign csum_plain  = ip4_csum(len14, 16'h0000, cfg_i.local_ip4, cfg_i.remote_ip4);
  assign csum_tunnel = ip4_csum(len62, FRAG_DF, cfg_i.local_ip4, cfg_i.remote_ip4);

  assign eth_ip4 = {cfg_i.remote_mac, cfg_i.local_mac, ETYPE_IP4};
  assign eth_ip6 = {cfg_i.remote_mac, cfg_i.local_mac, ETYPE_IP6};
  assign ip6_plain  = {FLOW_PLAIN, len54, PROTO_UDP, DEF_TTL, cfg_i.self_ip6_high,
                       cfg_i.self_ip6_low, cfg_i.dest_ip6_high, cfg_i.dest_ip6_low};
  assign ip6_tunnel = {FLOW_TUNNEL, len54, NH_DSTOPT, DEF_TTL, cfg_i.self_ip6_high,
                       cfg_i.self_ip6_low, cfg_i.dest_ip6_high, cfg_i.dest_ip6_low};

  assign d = req_i.stamp_enable ? NEED_W'(16) : NEED_W'(8);

  always_comb begin
    frame  = '0;
    need_o = '0;
    case (req_i.cmd)
      CMD_IP4_UDP: begin
        need_o = NEED_W'(42) + d;
        frame[FRAME_BITS-1 -: 464] = {eth_ip4,
          IP4_VER_IHL, len14, 16'h0000, 16'h0000, DEF_TTL, PROTO_UDP, csum_plain,
          cfg_i.local_ip4, cfg_i.remote_ip4,
          UDP_SRC_PORT, port_i, len34, 16'h0000, magic_le, stamp_le};
      end
      CMD_IP6_UDP: begin
        need_o = NEED_W'(62) + d;
        frame[FRAME_BITS-1 -: 624] = {eth_ip6, ip6_plain,
          UDP_SRC_PORT, port_i, len54, 16'h0000, magic_le, stamp_le};
      end
      CMD_IP4_IN_IP6: begin
        need_o = NEED_W'(90) + d;
        frame[FRAME_BITS-1 -: 848] = {eth_ip6, ip6_tunnel, DSTOPT_BYTES,
          IP4_VER_IHL, len62, 16'h0000, FRAG_DF, DEF_TTL, PROTO_UDP, csum_tunnel,
          cfg_i.local_ip4, cfg_i.remote_ip4,
          UDP_SRC_PORT, port_i, len82, 16'h0000, magic_le, stamp_le};
      end
      CMD_ENCAP: begin
        need_o = NEED_W'(62);
        frame[FRAME_BITS-1 -: 496] = {eth_ip6, ip6_tunnel, DSTOPT_BYTES};
      end
      CMD_DECAP: begin
        need_o = NEED_W'(14);
        frame[FRAME_BITS-1 -: 112] = eth_ip4;
      end
      default: begin
        need_o = '0;
      end
    endcase
  end

  assign too_short_o = len < 16'(need_o);

  always_comb begin
    for (int k = 0; k < FRAME_WORDS; k++) begin
      words_o[k] = frame[FRAME_BITS-1-64*k -: 64];
    end
  end

endmodule
